### rtl/complex_fixed_point_alu_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the complex fixed-point ALU
// Concurrent checks, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_FIXED_POINT_ALU_MACROS_SVH
`define COMPLEX_FIXED_POINT_ALU_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define CFA_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cfa assertion failed");
// next-cycle implication
`define CFA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cfa assertion failed");
`else
`define CFA_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define CFA_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

### rtl/cfa_pkg.sv
// ----------------------------------------------------------------------------
// cfa_pkg
// Shared types, constants and arithmetic helpers of the complex ALU.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cfa_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;
   localparam int INT_BITS  = WORD_BITS - FRAC_BITS;
   localparam int PROD_BITS = 2 * WORD_BITS;
   localparam int WIDE_BITS = PROD_BITS + 1;
   localparam int DEN_BITS  = PROD_BITS;
   localparam int NUM_CELLS = WORD_BITS;

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic signed [PROD_BITS-1:0] prod_type;
   typedef logic signed [WIDE_BITS-1:0] wide_type;
   typedef logic [DEN_BITS-1:0]         den_type;

   localparam wide_type ONE_FIX = wide_type'(1) <<< FRAC_BITS;

   typedef enum logic [3:0] {
      ACT_ADD    = 4'd0,
      ACT_SUB    = 4'd1,
      ACT_MUL    = 4'd2,
      ACT_DIV    = 4'd3,
      ACT_MOD    = 4'd4,
      ACT_EQ     = 4'd5,
      ACT_NE     = 4'd6,
      ACT_GT     = 4'd7,
      ACT_GE     = 4'd8,
      ACT_LT     = 4'd9,
      ACT_LE     = 4'd10,
      ACT_ISZERO = 4'd11,
      ACT_INC    = 4'd12,
      ACT_DEC    = 4'd13,
      ACT_PASS_B = 4'd14
   } action_type;

   typedef enum logic [1:0] {
      KIND_PLAIN,
      KIND_DIV,
      KIND_MOD
   } kind_type;

   // sideband that travels with a transaction down the divider row
   typedef struct packed {
      logic     valid;
      kind_type kind;
      word_type re;
      word_type im;
      logic     truth;
      logic     err;
      logic     ov;
      logic     neg_re;
      logic     neg_im;
      logic     big_re;
      logic     big_im;
   } side_type;

   // partial remainder plus shift word: dividend bits out at the top,
   // quotient bits in at the bottom
   typedef struct packed {
      den_type              rem;
      logic [WORD_BITS-1:0] nq;
   } lane_type;

   typedef struct packed {
      word_type val;
      logic     ov;
   } sat_type;

   function automatic sat_type sat_word(input wide_type x);
      sat_type o;
      o.ov  = !((&x[WIDE_BITS-1:WORD_BITS-1]) || !(|x[WIDE_BITS-1:WORD_BITS-1]));
      o.val = word_type'(x);
      if (o.ov) begin
         o.val = x[WIDE_BITS-1] ? {1'b1, {(WORD_BITS-1){1'b0}}}
                                : {1'b0, {(WORD_BITS-1){1'b1}}};
      end
      return o;
   endfunction

   // one restoring step: shift in the next dividend bit, subtract if it fits
   function automatic lane_type lane_step(input lane_type l, input den_type den);
      logic [DEN_BITS:0] trial;
      logic [DEN_BITS:0] diff;
      lane_type          o;
      trial = {l.rem, l.nq[WORD_BITS-1]};
      diff  = trial - {1'b0, den};
      o.rem = diff[DEN_BITS] ? trial[DEN_BITS-1:0] : diff[DEN_BITS-1:0];
      o.nq  = {l.nq[WORD_BITS-2:0], !diff[DEN_BITS]};
      return o;
   endfunction

   function automatic sat_type div_finish(input lane_type l, input logic neg,
                                          input logic big);
      logic [WORD_BITS-1:0] lim;
      logic [WORD_BITS-1:0] quo;
      sat_type              o;
      lim  = neg ? {1'b1, {(WORD_BITS-1){1'b0}}} : {1'b0, {(WORD_BITS-1){1'b1}}};
      quo  = l.nq;
      o.ov = big || (quo > lim);
      if (o.ov) begin
         quo = lim;
      end
      o.val = neg ? word_type'(-quo) : word_type'(quo);
      return o;
   endfunction

   function automatic word_type mod_finish(input lane_type l, input logic neg);
      logic [WORD_BITS-1:0] r;
      r = l.rem[WORD_BITS-1:0];
      return neg ? word_type'(-r) : word_type'(r);
   endfunction

endpackage

`default_nettype wire

### rtl/cfa_div_cell.sv
// ----------------------------------------------------------------------------
// cfa_div_cell
// One restoring-division cell: one quotient bit per lane, then hand on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cfa_div_cell
   import cfa_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     advance,
   input  wire side_type side_in,
   input  wire lane_type re_in,
   input  wire lane_type im_in,
   input  wire den_type  den_in,
   output side_type      side_out,
   output lane_type      re_out,
   output lane_type      im_out,
   output den_type       den_out
);

   side_type side_ff;
   lane_type re_ff, re_in_step;
   lane_type im_ff, im_in_step;
   den_type  den_ff;

   assign re_in_step = lane_step(re_in, den_in);
   assign im_in_step = lane_step(im_in, den_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.valid <= 1'b0;
      end else if (advance) begin
         side_ff.valid <= side_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff.kind   <= side_in.kind;
         side_ff.re     <= side_in.re;
         side_ff.im     <= side_in.im;
         side_ff.truth  <= side_in.truth;
         side_ff.err    <= side_in.err;
         side_ff.ov     <= side_in.ov;
         side_ff.neg_re <= side_in.neg_re;
         side_ff.neg_im <= side_in.neg_im;
         side_ff.big_re <= side_in.big_re;
         side_ff.big_im <= side_in.big_im;
         re_ff          <= re_in_step;
         im_ff          <= im_in_step;
         den_ff         <= den_in;
      end
   end

   assign side_out = side_ff;
   assign re_out   = re_ff;
   assign im_out   = im_ff;
   assign den_out  = den_ff;

endmodule

`default_nettype wire

### rtl/complex_fixed_point_alu.sv
// ----------------------------------------------------------------------------
// complex_fixed_point_alu
// Complex Q16.16 ALU: add, sub, mul, div, mod, compares, inc, dec, pass b.
// Stages: 3 front stages, 32 divider cells, 1 output register; the same
//    path for every action.
// Throughput: one transaction per cycle unless rsp_stall holds a result;
//    one quotient bit per divider cell, so a new division enters every cycle.
// Reset: synchronous, clears all valid bits; the pipeline comes up empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "complex_fixed_point_alu_macros.svh"

module complex_fixed_point_alu
   import cfa_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [3:0]             req_action,
   input  wire logic signed [31:0]     req_a_re,
   input  wire logic signed [31:0]     req_a_im,
   input  wire logic signed [31:0]     req_b_re,
   input  wire logic signed [31:0]     req_b_im,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic signed [31:0]          rsp_res_re,
   output logic signed [31:0]          rsp_res_im,
   output logic                        rsp_truth,
   output logic                        rsp_div_error,
   output logic                        rsp_overflow
);

   // The whole pipeline moves as one: it advances whenever the output
   // register is empty or its transaction is being taken.
   logic advance;

   // ---------------- stage 1: capture the transaction ----------------
   logic       p1_valid_ff;
   logic [3:0] p1_act_ff;
   word_type   p1_ar_ff, p1_ai_ff, p1_br_ff, p1_bi_ff;

   // ---------------- stage 2: products and simple actions ----------------
   logic     p2_valid_ff;
   side_type p2_side_ff, p2_side_in;
   prod_type p2_rr_ff, p2_ii_ff, p2_ri_ff, p2_ir_ff, p2_sqr_ff, p2_sqi_ff;
   logic [WORD_BITS-1:0] p2_mx_re_ff, p2_mx_im_ff, p2_mm_ff;
   logic [WORD_BITS-1:0] p2_mx_re_in, p2_mx_im_in, p2_mm_in;

   // ---------------- stage 3: sums, multiply result, divider set-up --------
   logic     p3_valid_ff;
   side_type p3_side_ff, p3_side_in;
   lane_type p3_re_ff, p3_im_ff, p3_re_in, p3_im_in;
   den_type  p3_den_ff, p3_den_in;

   // ---------------- divider row ----------------
   side_type cell_side [0:NUM_CELLS];
   lane_type cell_re   [0:NUM_CELLS];
   lane_type cell_im   [0:NUM_CELLS];
   den_type  cell_den  [0:NUM_CELLS];

   // ---------------- output register ----------------
   logic     rsp_valid_ff;
   word_type rsp_re_ff, rsp_im_ff, rsp_re_in, rsp_im_in;
   logic     rsp_truth_ff, rsp_err_ff, rsp_ov_ff, rsp_ov_in;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         p3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         p1_valid_ff  <= req_valid;
         p2_valid_ff  <= p1_valid_ff;
         p3_valid_ff  <= p2_valid_ff;
         rsp_valid_ff <= cell_side[NUM_CELLS].valid;
      end
   end

   // stage 1 payload: hold the operands
   always_ff @(posedge clock) begin
      if (advance) begin
         p1_act_ff <= req_action;
         p1_ar_ff  <= req_a_re;
         p1_ai_ff  <= req_a_im;
         p1_br_ff  <= req_b_re;
         p1_bi_ff  <= req_b_im;
      end
   end

   // stage 2: decode and finish every action that needs no product or division
   always_comb begin
      sat_type s0, s1;
      p2_side_in       = '0;
      p2_side_in.valid = p1_valid_ff;
      p2_side_in.kind  = KIND_PLAIN;
      p2_mx_re_in      = p1_ar_ff[WORD_BITS-1] ? -p1_ar_ff : p1_ar_ff;
      p2_mx_im_in      = p1_ai_ff[WORD_BITS-1] ? -p1_ai_ff : p1_ai_ff;
      p2_mm_in         = p1_br_ff[WORD_BITS-1] ? -p1_br_ff : p1_br_ff;
      s0 = '0;
      s1 = '0;
      unique case (action_type'(p1_act_ff))
         ACT_ADD: begin
            s0 = sat_word(wide_type'(p1_ar_ff) + wide_type'(p1_br_ff));
            s1 = sat_word(wide_type'(p1_ai_ff) + wide_type'(p1_bi_ff));
         end
         ACT_SUB: begin
            s0 = sat_word(wide_type'(p1_ar_ff) - wide_type'(p1_br_ff));
            s1 = sat_word(wide_type'(p1_ai_ff) - wide_type'(p1_bi_ff));
         end
         ACT_INC: begin
            s0 = sat_word(wide_type'(p1_ar_ff) + ONE_FIX);
            s1 = sat_word(wide_type'(p1_ai_ff) + ONE_FIX);
         end
         ACT_DEC: begin
            s0 = sat_word(wide_type'(p1_ar_ff) - ONE_FIX);
            s1 = sat_word(wide_type'(p1_ai_ff) - ONE_FIX);
         end
         ACT_PASS_B: begin
            s0.val = p1_br_ff;
            s1.val = p1_bi_ff;
         end
         ACT_MUL: p2_side_in.kind = KIND_DIV;
         ACT_DIV: begin
            // a zero divisor stays plain with zero parts
            if (p1_br_ff == '0 && p1_bi_ff == '0) begin
               p2_side_in.err = 1'b1;
            end else begin
               p2_side_in.kind = KIND_DIV;
            end
         end
         ACT_MOD: begin
            if (p1_br_ff == '0) begin
               p2_side_in.err = 1'b1;
            end else begin
               p2_side_in.kind   = KIND_MOD;
               p2_side_in.neg_re = p1_ar_ff[WORD_BITS-1];
               p2_side_in.neg_im = p1_ai_ff[WORD_BITS-1];
            end
         end
         ACT_EQ: p2_side_in.truth = (p1_ar_ff == p1_br_ff) && (p1_ai_ff == p1_bi_ff);
         ACT_NE: p2_side_in.truth = (p1_ar_ff != p1_br_ff) || (p1_ai_ff != p1_bi_ff);
         ACT_GT: p2_side_in.truth = (p1_ar_ff > p1_br_ff)
                    || ((p1_ar_ff == p1_br_ff) && (p1_ai_ff > p1_bi_ff));
         ACT_GE: p2_side_in.truth = (p1_ar_ff >= p1_br_ff) && (p1_ai_ff >= p1_bi_ff);
         ACT_LT: p2_side_in.truth = (p1_ar_ff < p1_br_ff)
                    || ((p1_ar_ff == p1_br_ff) && (p1_ai_ff < p1_bi_ff));
         ACT_LE: p2_side_in.truth = (p1_ar_ff <= p1_br_ff) && (p1_ai_ff <= p1_bi_ff);
         ACT_ISZERO: p2_side_in.truth = (p1_ar_ff == '0) && (p1_ai_ff == '0);
         default: p2_side_in.kind = KIND_PLAIN;
      endcase
      p2_side_in.re = s0.val;
      p2_side_in.im = s1.val;
      p2_side_in.ov = s0.ov || s1.ov;
   end

   // The multiply action borrows KIND_DIV in stage 2 only to mark "needs
   // products"; stage 3 tells it apart by the held action code.
   logic [3:0] p2_act_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         p2_side_ff  <= p2_side_in;
         p2_act_ff   <= p1_act_ff;
         p2_rr_ff    <= prod_type'(p1_ar_ff) * prod_type'(p1_br_ff);
         p2_ii_ff    <= prod_type'(p1_ai_ff) * prod_type'(p1_bi_ff);
         p2_ri_ff    <= prod_type'(p1_ar_ff) * prod_type'(p1_bi_ff);
         p2_ir_ff    <= prod_type'(p1_ai_ff) * prod_type'(p1_br_ff);
         p2_sqr_ff   <= prod_type'(p1_br_ff) * prod_type'(p1_br_ff);
         p2_sqi_ff   <= prod_type'(p1_bi_ff) * prod_type'(p1_bi_ff);
         p2_mx_re_ff <= p2_mx_re_in;
         p2_mx_im_ff <= p2_mx_im_in;
         p2_mm_ff    <= p2_mm_in;
      end
   end

   // stage 3: finish multiply, form divider numerators and denominator
   always_comb begin
      wide_type sum_re, sum_im, mul_re, mul_im;
      wide_type mag_re, mag_im;
      sat_type  m0, m1;
      p3_side_in       = p2_side_ff;
      p3_side_in.valid = p2_valid_ff;
      sum_re = wide_type'(p2_rr_ff) + wide_type'(p2_ii_ff);
      sum_im = wide_type'(p2_ir_ff) - wide_type'(p2_ri_ff);
      mul_re = (wide_type'(p2_rr_ff) - wide_type'(p2_ii_ff)) >>> FRAC_BITS;
      mul_im = (wide_type'(p2_ri_ff) + wide_type'(p2_ir_ff)) >>> FRAC_BITS;
      mag_re = sum_re[WIDE_BITS-1] ? -sum_re : sum_re;
      mag_im = sum_im[WIDE_BITS-1] ? -sum_im : sum_im;
      m0 = sat_word(mul_re);
      m1 = sat_word(mul_im);
      p3_den_in = den_type'(p2_sqr_ff) + den_type'(p2_sqi_ff);
      // division: dividend is mag << FRAC_BITS, quotient kept to WORD_BITS
      p3_re_in.rem = den_type'(mag_re[PROD_BITS-1:INT_BITS]);
      p3_re_in.nq  = {mag_re[INT_BITS-1:0], {FRAC_BITS{1'b0}}};
      p3_im_in.rem = den_type'(mag_im[PROD_BITS-1:INT_BITS]);
      p3_im_in.nq  = {mag_im[INT_BITS-1:0], {FRAC_BITS{1'b0}}};
      if (action_type'(p2_act_ff) == ACT_MUL) begin
         p3_side_in.kind = KIND_PLAIN;
         p3_side_in.re   = m0.val;
         p3_side_in.im   = m1.val;
         p3_side_in.ov   = m0.ov || m1.ov;
      end else if (p2_side_ff.kind == KIND_DIV) begin
         p3_side_in.neg_re = sum_re[WIDE_BITS-1];
         p3_side_in.neg_im = sum_im[WIDE_BITS-1];
      end else if (p2_side_ff.kind == KIND_MOD) begin
         p3_den_in    = den_type'(p2_mm_ff);
         p3_re_in.rem = '0;
         p3_re_in.nq  = p2_mx_re_ff;
         p3_im_in.rem = '0;
         p3_im_in.nq  = p2_mx_im_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p3_side_ff <= p3_side_in;
         p3_re_ff   <= p3_re_in;
         p3_im_ff   <= p3_im_in;
         p3_den_ff  <= p3_den_in;
      end
   end

   // Head of the row: flag quotients that cannot fit in WORD_BITS bits
   always_comb begin
      cell_side[0]        = p3_side_ff;
      cell_side[0].valid  = p3_valid_ff;
      cell_side[0].big_re = p3_re_ff.rem >= p3_den_ff;
      cell_side[0].big_im = p3_im_ff.rem >= p3_den_ff;
      cell_re[0]          = p3_re_ff;
      cell_im[0]          = p3_im_ff;
      cell_den[0]         = p3_den_ff;
   end

   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
      cfa_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .side_in  (cell_side[g]),
         .re_in    (cell_re[g]),
         .im_in    (cell_im[g]),
         .den_in   (cell_den[g]),
         .side_out (cell_side[g+1]),
         .re_out   (cell_re[g+1]),
         .im_out   (cell_im[g+1]),
         .den_out  (cell_den[g+1])
      );
   end

   // Tail: saturate quotients, sign remainders, merge plain results
   always_comb begin
      sat_type q0, q1;
      q0 = div_finish(cell_re[NUM_CELLS], cell_side[NUM_CELLS].neg_re,
                      cell_side[NUM_CELLS].big_re);
      q1 = div_finish(cell_im[NUM_CELLS], cell_side[NUM_CELLS].neg_im,
                      cell_side[NUM_CELLS].big_im);
      rsp_re_in = cell_side[NUM_CELLS].re;
      rsp_im_in = cell_side[NUM_CELLS].im;
      rsp_ov_in = cell_side[NUM_CELLS].ov;
      case (cell_side[NUM_CELLS].kind)
         KIND_DIV: begin
            rsp_re_in = q0.val;
            rsp_im_in = q1.val;
            rsp_ov_in = q0.ov || q1.ov;
         end
         KIND_MOD: begin
            rsp_re_in = mod_finish(cell_re[NUM_CELLS], cell_side[NUM_CELLS].neg_re);
            rsp_im_in = mod_finish(cell_im[NUM_CELLS], cell_side[NUM_CELLS].neg_im);
            rsp_ov_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_re_ff    <= rsp_re_in;
         rsp_im_ff    <= rsp_im_in;
         rsp_truth_ff <= cell_side[NUM_CELLS].truth;
         rsp_err_ff   <= cell_side[NUM_CELLS].err;
         rsp_ov_ff    <= rsp_ov_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_res_re    = rsp_re_ff;
   assign rsp_res_im    = rsp_im_ff;
   assign rsp_truth     = rsp_truth_ff;
   assign rsp_div_error = rsp_err_ff;
   assign rsp_overflow  = rsp_ov_ff;

   // ---------------- checks ----------------
   `CFA_ASSERT_SAME(a_err_zero, clock, reset, rsp_valid_ff && rsp_err_ff, rsp_re_ff == '0 && rsp_im_ff == '0 && !rsp_ov_ff)
   `CFA_ASSERT_SAME(a_truth_only, clock, reset, rsp_valid_ff && rsp_truth_ff, rsp_re_ff == '0 && rsp_im_ff == '0 && !rsp_err_ff && !rsp_ov_ff)
   `CFA_ASSERT_NEXT(a_accept_enters, clock, reset, req_valid && !req_stall, p1_valid_ff)
   `CFA_ASSERT_NEXT(a_hold_tail, clock, reset, !advance, $stable(cell_side[NUM_CELLS].valid))

endmodule

`default_nettype wire

### verif/tb_complex_fixed_point_alu.sv
// ----------------------------------------------------------------------------
// tb_complex_fixed_point_alu
// Self-checking bench for the complex Q16.16 ALU. Every accepted transaction
// is predicted in-bench (saturating add/sub/inc/dec, floor-rounded multiply,
// truncating divide, signed remainder, compares) and results are checked in
// order against the queue of predictions, under varying idle patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_complex_fixed_point_alu
   import cfa_pkg::*;
();

   typedef struct packed {
      logic signed [31:0] re;
      logic signed [31:0] im;
      logic               truth;
      logic               err;
      logic               ov;
   } alu_result_type;

   localparam longint MAX_W = 64'sd2147483647;
   localparam longint MIN_W = -64'sd2147483648;
   localparam longint ONE_Q = 64'sd65536;

   logic clock, reset;
   logic req_valid, req_stall;
   logic [3:0] req_action;
   logic signed [31:0] req_a_re, req_a_im, req_b_re, req_b_im;
   logic rsp_valid, rsp_stall;
   logic signed [31:0] rsp_res_re, rsp_res_im;
   logic rsp_truth, rsp_div_error, rsp_overflow;

   alu_result_type pending_results[$];
   int             fail_count;
   int             send_idle_pct;
   int             recv_idle_pct;

   complex_fixed_point_alu dut (.*);

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // clamp to the word range, raising the overflow flag when clamped
   function automatic logic signed [31:0] clamp_word(input logic signed [127:0] x,
                                                     inout logic ov);
      if (x > MAX_W) begin
         ov = 1'b1;
         return 32'(MAX_W);
      end
      if (x < MIN_W) begin
         ov = 1'b1;
         return 32'(MIN_W);
      end
      return 32'(x);
   endfunction

   // (num << 16) / den, truncated toward zero, saturated
   function automatic logic signed [31:0] div_round(input logic signed [127:0] num,
                                                    input logic signed [127:0] den,
                                                    inout logic ov);
      logic signed [127:0] q;
      q = (num <<< 16) / den;
      return clamp_word(q, ov);
   endfunction

   function automatic alu_result_type predict_alu(input logic [3:0] act,
                                                  input longint ar, input longint ai,
                                                  input longint br, input longint bi);
      alu_result_type r;
      logic signed [127:0] den, pr, pi;
      logic ov;
      r  = '0;
      ov = 1'b0;
      case (act)
         ACT_ADD: begin
            r.re = clamp_word(128'(ar + br), ov);
            r.im = clamp_word(128'(ai + bi), ov);
         end
         ACT_SUB: begin
            r.re = clamp_word(128'(ar - br), ov);
            r.im = clamp_word(128'(ai - bi), ov);
         end
         ACT_MUL: begin
            pr = 128'(ar) * br - 128'(ai) * bi;
            pi = 128'(ar) * bi + 128'(ai) * br;
            // arithmetic shift floors, as the block rounds toward minus infinity
            r.re = clamp_word(pr >>> 16, ov);
            r.im = clamp_word(pi >>> 16, ov);
         end
         ACT_DIV: begin
            den = 128'(br) * br + 128'(bi) * bi;
            if (den == 0) r.err = 1'b1;
            else begin
               r.re = div_round(128'(ar) * br + 128'(ai) * bi, den, ov);
               r.im = div_round(128'(ai) * br - 128'(ar) * bi, den, ov);
            end
         end
         ACT_MOD: begin
            if (br == 0) r.err = 1'b1;
            else begin
               // SV % truncates and follows the dividend's sign
               r.re = 32'(ar % br);
               r.im = 32'(ai % br);
            end
         end
         ACT_EQ:     r.truth = (ar == br) && (ai == bi);
         ACT_NE:     r.truth = (ar != br) || (ai != bi);
         ACT_GT:     r.truth = (ar > br) || (ar == br && ai > bi);
         ACT_GE:     r.truth = (ar >= br) && (ai >= bi);
         ACT_LT:     r.truth = (ar < br) || (ar == br && ai < bi);
         ACT_LE:     r.truth = (ar <= br) && (ai <= bi);
         ACT_ISZERO: r.truth = (ar == 0) && (ai == 0);
         ACT_INC: begin
            r.re = clamp_word(128'(ar + ONE_Q), ov);
            r.im = clamp_word(128'(ai + ONE_Q), ov);
         end
         ACT_DEC: begin
            r.re = clamp_word(128'(ar - ONE_Q), ov);
            r.im = clamp_word(128'(ai - ONE_Q), ov);
         end
         ACT_PASS_B: begin
            r.re = 32'(br);
            r.im = 32'(bi);
         end
         default: ;
      endcase
      r.ov = ov;
      return r;
   endfunction

   // hold the transaction until accepted; predict it on acceptance
   task automatic send_operands(input logic [3:0] act, input logic signed [31:0] ar,
                                input logic signed [31:0] ai, input logic signed [31:0] br,
                                input logic signed [31:0] bi);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= act;
      req_a_re   <= ar;
      req_a_im   <= ai;
      req_b_re   <= br;
      req_b_im   <= bi;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(predict_alu(act, longint'(ar), longint'(ai),
                                            longint'(br), longint'(bi)));
   endtask

   task automatic drop_valid();
      req_valid <= 1'b0;
   endtask

   function automatic logic signed [31:0] rand_word();
      case ($urandom_range(5))
         0: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
         1: return $signed($urandom_range(8)) - 4;
         2: return $signed($urandom_range(6)) <<< 16;
         3: return $signed($urandom) >>> 12;
         default: return $urandom;
      endcase
   endfunction

   // drive the receiver stall at random and check each result transaction
   always @(posedge clock) begin
      alu_result_type want;
      if (reset) rsp_stall <= 1'b0;
      else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("result transaction with nothing expected");
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_res_re !== want.re) begin
                  $error("res_re expected %0d actual %0d", want.re, rsp_res_re);
                  fail_count++;
               end
               if (rsp_res_im !== want.im) begin
                  $error("res_im expected %0d actual %0d", want.im, rsp_res_im);
                  fail_count++;
               end
               if (rsp_truth !== want.truth) begin
                  $error("truth expected %0d actual %0d", want.truth, rsp_truth);
                  fail_count++;
               end
               if (rsp_div_error !== want.err) begin
                  $error("div_error expected %0d actual %0d", want.err, rsp_div_error);
                  fail_count++;
               end
               if (rsp_overflow !== want.ov) begin
                  $error("overflow expected %0d actual %0d", want.ov, rsp_overflow);
                  fail_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // extremes of every field and each action at least once
   task automatic test_directed();
      action_type a;
      send_operands(ACT_ADD, 32'sh7fffffff, 32'sh80000000, 32'sh1, -32'sh1);
      send_operands(ACT_SUB, 32'sh80000000, 32'sh7fffffff, 32'sh1, -32'sh1);
      send_operands(ACT_MUL, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
      send_operands(ACT_MUL, -32'sh1, 32'sh0, 32'sh1, 32'sh0);
      send_operands(ACT_DIV, 32'sh10000, 32'sh20000, 32'sh0, 32'sh0);
      send_operands(ACT_DIV, 32'sh7fffffff, 32'sh80000000, 32'sh1, 32'sh0);
      send_operands(ACT_DIV, 32'sh80000000, 32'sh0, -32'sh10000, 32'sh0);
      send_operands(ACT_DIV, -32'sh30000, 32'sh10000, 32'sh20000, 32'sh10000);
      send_operands(ACT_MOD, -32'sh7, 32'sh7, 32'sh0, 32'sh5);
      send_operands(ACT_MOD, 32'sh80000000, -32'sh7, 32'sh80000000, 32'sh0);
      send_operands(ACT_MOD, -32'sh7, 32'sh7, -32'sh3, 32'sh0);
      send_operands(ACT_INC, 32'sh7fffffff, 32'sh0, 32'sh0, 32'sh0);
      send_operands(ACT_DEC, 32'sh80000000, 32'sh0, 32'sh0, 32'sh0);
      send_operands(ACT_PASS_B, 32'sh0, 32'sh0, 32'sh80000000, 32'sh7fffffff);
      send_operands(ACT_ISZERO, 32'sh0, 32'sh0, 32'sh1, 32'sh1);
      send_operands(4'hf, 32'sh5, 32'sh5, 32'sh5, 32'sh5);
      // compares with equal real parts, so the imaginary part decides
      for (a = ACT_EQ; a <= ACT_LE; a = action_type'(a + 1)) begin
         send_operands(a, 32'sh10000, 32'sh3, 32'sh10000, -32'sh3);
      end
   endtask

   task automatic test_random(input int count);
      logic signed [31:0] ar, ai, br, bi;
      repeat (count) begin
         ar = rand_word();
         ai = rand_word();
         br = $urandom_range(9) == 0 ? ar : rand_word();
         bi = $urandom_range(9) == 0 ? ai : rand_word();
         send_operands(4'($urandom_range(15)), ar, ai, br, bi);
      end
   endtask

   // run the random set under each idle pattern
   task automatic test_idle_patterns();
      send_idle_pct = 14;
      recv_idle_pct = 58;
      test_random(500);
      send_idle_pct = 58;
      recv_idle_pct = 14;
      test_random(500);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(500);
   endtask

   initial begin
      fail_count    = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      clock         = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_action    = '0;
      req_a_re      = '0;
      req_a_im      = '0;
      req_b_re      = '0;
      req_b_im      = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_idle_patterns();
      drop_valid();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      // drain, then allow the pipeline latency for any stray result
      while (pending_results.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

   initial begin
      #2ms;
      $display("Test completed with failures");
      $finish;
   end

endmodule
